FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define URLD_ASSERT(label, clk, rstn, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define URLD_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/urld_pkg.sv
// ----------------------------------------------------------------------------
// urld_pkg
// Types and character constants for the URL percent decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package urld_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	localparam int unsigned GRP_MAX = 3;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	// Decoded bytes produced by one input transaction; last applies to the
	// final byte of the group only.
	typedef struct packed {
		logic [1:0]               cnt;
		logic [GRP_MAX-1:0][7:0]  bytes;
		logic                     last;
	} grp_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
		       (c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c <= 8'h39) v = c - 8'h30;
		else if (c >= 8'h61) v = c - 8'h57;
		else v = c - 8'h37;
		return v[3:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/urld_decode.sv
// ----------------------------------------------------------------------------
// urld_decode
// Combinational decode of one encoded byte against the held escape state.
// ----------------------------------------------------------------------------
`default_nettype none

module urld_decode import urld_pkg::*; (
	input  wire phase_t     phase,
	input  wire logic [7:0] held,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output grp_t            grp,
	output phase_t          phase_nx,
	output logic [7:0]      held_nx
);

	logic       cur_hex;
	logic       held_hex;
	logic [1:0] pre_cnt;
	logic       pl_emit;
	logic [7:0] pl_byte;
	phase_t     pl_phase;

	always_comb begin
		cur_hex  = is_hex(in_byte);
		held_hex = is_hex(held);

		// byte handled as if nothing were held
		if (in_byte == CH_PERCENT) begin
			pl_emit  = in_last;
			pl_byte  = CH_PERCENT;
			pl_phase = in_last ? PH_IDLE : PH_PCT;
		end else begin
			pl_emit  = 1'b1;
			pl_byte  = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
			pl_phase = PH_IDLE;
		end

		unique case (phase)
			PH_PCT:   pre_cnt = 2'd1;
			PH_DIGIT: pre_cnt = 2'd2;
			default:  pre_cnt = 2'd0;
		endcase

		grp.cnt      = pre_cnt + {1'b0, pl_emit};
		grp.bytes[0] = (pre_cnt != 2'd0) ? CH_PERCENT : pl_byte;
		grp.bytes[1] = (pre_cnt == 2'd2) ? held : pl_byte;
		grp.bytes[2] = pl_byte;
		grp.last     = in_last;
		phase_nx     = pl_phase;
		held_nx      = held;

		if (phase == PH_PCT && cur_hex) begin
			if (in_last) begin
				// escape cut short: flush '%' and the digit
				grp.cnt      = 2'd2;
				grp.bytes[1] = in_byte;
				phase_nx     = PH_IDLE;
			end else begin
				grp.cnt  = 2'd0;
				held_nx  = in_byte;
				phase_nx = PH_DIGIT;
			end
		end else if (phase == PH_DIGIT && cur_hex && held_hex) begin
			grp.cnt      = 2'd1;
			grp.bytes[0] = {hex_val(held), hex_val(in_byte)};
			phase_nx     = PH_IDLE;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder
// Form-urlencoded percent decoder, one encoded byte per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one encoded byte per
//   transaction, with in_last on the final byte of a string. Output channel
//   (out_valid/out_ready) carries decoded bytes, with out_last on the final
//   decoded byte of each string.
//   '%' plus two hex digits becomes one byte, '+' becomes a space, and a
//   broken escape is passed through literally. An input transaction yields
//   zero to three output transactions.
//   A group passes stage 1, then stage 2 (the output register). Throughput:
//   one input per cycle while each input yields at most one byte and the
//   receiver does not stall; a group of N bytes holds the output register
//   for N transactions, while the stage behind it parks one more non-empty
//   group (inputs that decode to nothing keep flowing until it arrives).
//   Escape state (held '%' and digit) updates as each input is accepted.
//   Reset (arst_n low) empties both group registers and clears the escape
//   state. When the receiver stalls, hold the current byte on the output,
//   park one further group in the stage before it, then drop in_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_decoder import urld_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	phase_t     phase_q;
	logic [7:0] held_q;
	phase_t     phase_nx;
	logic [7:0] held_nx;
	grp_t       dec_grp;

	// Stage 1: decoded group waiting for the output register
	logic       valid_s1;
	grp_t       grp_s1;
	// Stage 2: group being drained onto the output, one byte per transaction
	logic       valid_s2;
	grp_t       grp_s2;
	logic [1:0] idx_s2;

	logic       in_acc;
	logic       out_acc;
	logic       s2_end;
	logic       s2_free;
	logic       s1_move;

	urld_decode u_decode (
		.phase    (phase_q),
		.held     (held_q),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.grp      (dec_grp),
		.phase_nx (phase_nx),
		.held_nx  (held_nx)
	);

	assign out_acc  = out_valid && out_ready;
	assign s2_end   = (idx_s2 == (grp_s2.cnt - 2'd1));
	// output register empties at this edge, or is already empty
	assign s2_free  = !valid_s2 || (out_ready && s2_end);
	assign s1_move  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;
	assign in_acc   = in_valid && in_ready;

	assign out_valid = valid_s2;
	assign out_byte  = grp_s2.bytes[idx_s2];
	assign out_last  = grp_s2.last && s2_end;

	// Escape state advances with every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (in_acc) begin
			phase_q <= phase_nx;
			held_q  <= held_nx;
		end
	end

	// Stage 1: load a non-empty group, release it into stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= (dec_grp.cnt != 2'd0);
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			grp_s1 <= dec_grp;
		end
	end

	// Stage 2: step through the group, one byte per output transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= '0;
		end else if (s1_move) begin
			valid_s2 <= 1'b1;
			idx_s2   <= '0;
		end else if (out_acc) begin
			if (s2_end) begin
				valid_s2 <= 1'b0;
				idx_s2   <= '0;
			end else begin
				idx_s2 <= idx_s2 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			grp_s2 <= grp_s1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/urld_checker.sv
// ----------------------------------------------------------------------------
// urld_checker
// Port-level checks on the URL percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module urld_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       out_last
);

	logic       out_stall;
	logic [9:0] out_view;

	assign out_stall = out_valid && !out_ready;
	assign out_view  = {out_valid, out_byte, out_last};

	// a stalled output holds its byte
	`URLD_ASSERT(a_out_hold, clk, arst_n, out_stall |=> $stable(out_view), "stalled output moved")

	// nothing offered while in reset
	`URLD_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !out_valid, "output valid in reset")

	// with the output register empty the input is never back-pressured
	`URLD_ASSERT_ALWAYS(a_idle_ready, clk, !out_valid |-> in_ready, "input stalled, output empty")

endmodule

bind url_percent_decoder urld_checker u_urld_checker (.*);

`default_nettype wire
